// ----- rtl/deque_with_positional_insert_assert.svh -----
// assertion macros used by the checker file
`ifndef DEQUE_WITH_POSITIONAL_INSERT_ASSERT_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_ASSERT_SVH

// property checked on every edge, also while reset is asserted
`define DWPI_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

// property checked only outside reset
`define DWPI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// ----- rtl/dwpi_pkg.sv -----
package dwpi_pkg;

	// queue geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// field widths
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// packed input word: action, value, position from the lowest bit up
	localparam int IN_BITS   = ACTION_W + VALUE_W + CNT_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int IN_VAL_LSB = ACTION_W;
	localparam int IN_POS_LSB = ACTION_W + VALUE_W;

	// packed output word: popped_value, status, size_after from the lowest bit up
	localparam int OUT_BITS     = VALUE_W + STATUS_W + CNT_W;
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_STAT_LSB = VALUE_W;
	localparam int OUT_SIZE_LSB = VALUE_W + STATUS_W;

	typedef logic signed [VALUE_W-1:0] word_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] index_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_BACK   = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_INSERT     = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		POP_NONE  = 2'd0,
		POP_BACK  = 2'd1,
		POP_FRONT = 2'd2
	} pop_kind_t;

	// per-cell load selection
	typedef struct packed {
		logic load;
		logic from_lower;
		logic from_upper;
	} cell_ctl_t;

	// decoded request from the control unit to the cell row
	typedef struct packed {
		logic      ins;
		logic      del_front;
		index_t    pos;
		pop_kind_t pop_kind;
		status_t   status;
		count_t    size_after;
	} row_cmd_t;

endpackage

// ----- rtl/dwpi_cell.sv -----
module dwpi_cell (
	input  logic                clk,
	input  dwpi_pkg::cell_ctl_t ctl,
	input  dwpi_pkg::word_t     new_word,
	input  dwpi_pkg::word_t     lower_word,
	input  dwpi_pkg::word_t     upper_word,
	output dwpi_pkg::word_t     word_q
);

	// take the new word, a neighbor's word, or hold
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= new_word;
		end else if (ctl.from_lower) begin
			word_q <= lower_word;
		end else if (ctl.from_upper) begin
			word_q <= upper_word;
		end
	end

endmodule

// ----- rtl/dwpi_ctrl.sv -----
module dwpi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  dwpi_pkg::action_t  action,
	input  dwpi_pkg::count_t   position,
	output dwpi_pkg::count_t   occupancy_q,
	output dwpi_pkg::row_cmd_t cmd
);

	logic full;
	logic empty;

	assign full  = (occupancy_q == dwpi_pkg::CNT_W'(dwpi_pkg::DEPTH));
	assign empty = (occupancy_q == '0);

	// decode the request against the current fill level
	always_comb begin
		cmd            = '0;
		cmd.pop_kind   = dwpi_pkg::POP_NONE;
		cmd.status     = dwpi_pkg::ST_DONE;
		cmd.size_after = occupancy_q;
		case (action)
			dwpi_pkg::ACT_PUSH_BACK, dwpi_pkg::ACT_PUSH_FRONT, dwpi_pkg::ACT_INSERT: begin
				if (full) begin
					cmd.status = dwpi_pkg::ST_FULL;
				end else if (action == dwpi_pkg::ACT_INSERT && position > occupancy_q) begin
					cmd.status = dwpi_pkg::ST_RANGE;
				end else begin
					cmd.ins        = 1'b1;
					cmd.size_after = occupancy_q + dwpi_pkg::CNT_W'(1);
					if (action == dwpi_pkg::ACT_PUSH_BACK) begin
						cmd.pos = occupancy_q[dwpi_pkg::IDX_W-1:0];
					end else if (action == dwpi_pkg::ACT_PUSH_FRONT) begin
						cmd.pos = '0;
					end else begin
						cmd.pos = position[dwpi_pkg::IDX_W-1:0];
					end
				end
			end
			dwpi_pkg::ACT_POP_BACK, dwpi_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					cmd.status = dwpi_pkg::ST_EMPTY;
				end else begin
					cmd.size_after = occupancy_q - dwpi_pkg::CNT_W'(1);
					if (action == dwpi_pkg::ACT_POP_FRONT) begin
						cmd.del_front = 1'b1;
						cmd.pop_kind  = dwpi_pkg::POP_FRONT;
					end else begin
						cmd.pop_kind  = dwpi_pkg::POP_BACK;
					end
				end
			end
			default: begin
				cmd.status = dwpi_pkg::ST_DONE;
			end
		endcase
	end

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (accept) begin
			occupancy_q <= cmd.size_after;
		end
	end

endmodule

// ----- rtl/deque_with_positional_insert.sv -----
// latency: a result word appears in the cycle after its request word is taken
// throughput: one request per cycle while results are taken; the shifting cell
// row applies any push, pop or insert as it is accepted and the result register frees as it is read
// reset: arst_n clears the fill level and the result valid; cell contents stay
// undefined until written and are never read before that
module deque_with_positional_insert (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// action[2:0], value[34:3], position[39:35]
	input  logic [dwpi_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// popped_value[31:0], status[33:32], size_after[38:34], zero pad above
	output logic [dwpi_pkg::OUT_W-1:0]  m_tdata
);

	logic                         accept;
	dwpi_pkg::action_t            action;
	dwpi_pkg::word_t              value;
	dwpi_pkg::count_t             position;
	dwpi_pkg::count_t             occupancy;
	dwpi_pkg::row_cmd_t           cmd;
	dwpi_pkg::word_t              cell_q [dwpi_pkg::DEPTH];
	dwpi_pkg::cell_ctl_t          cell_ctl [dwpi_pkg::DEPTH];
	dwpi_pkg::count_t             back_pos;
	dwpi_pkg::word_t              popped;
	logic                         m_tvalid_q;
	logic [dwpi_pkg::OUT_W-1:0]   m_tdata_q;

	// unpack the request word
	assign action   = dwpi_pkg::action_t'(s_tdata[dwpi_pkg::ACTION_W-1:0]);
	assign value    = s_tdata[dwpi_pkg::IN_VAL_LSB +: dwpi_pkg::VALUE_W];
	assign position = s_tdata[dwpi_pkg::IN_POS_LSB +: dwpi_pkg::CNT_W];

	// take a word whenever the result register is free or being emptied
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	dwpi_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.position    (position),
		.occupancy_q (occupancy),
		.cmd         (cmd)
	);

	// cell row: cell 0 is the front
	for (genvar i = 0; i < dwpi_pkg::DEPTH; i++) begin : g_cell
		dwpi_pkg::word_t lower_word;
		dwpi_pkg::word_t upper_word;

		if (i == 0) begin : g_first
			assign lower_word = cell_q[i];
		end else begin : g_lower
			assign lower_word = cell_q[i-1];
		end

		if (i == dwpi_pkg::DEPTH - 1) begin : g_last
			assign upper_word = cell_q[i];
		end else begin : g_upper
			assign upper_word = cell_q[i+1];
		end

		// insert opens a gap above the target, pop front closes toward the front
		assign cell_ctl[i].load       = accept && cmd.ins && (cmd.pos == dwpi_pkg::IDX_W'(i));
		assign cell_ctl[i].from_lower = accept && cmd.ins && (dwpi_pkg::IDX_W'(i) > cmd.pos);
		assign cell_ctl[i].from_upper = accept && cmd.del_front && (i != dwpi_pkg::DEPTH - 1);

		dwpi_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.new_word   (value),
			.lower_word (lower_word),
			.upper_word (upper_word),
			.word_q     (cell_q[i])
		);
	end

	// word leaving the queue, read before the row moves
	assign back_pos = occupancy - dwpi_pkg::CNT_W'(1);

	always_comb begin
		case (cmd.pop_kind)
			dwpi_pkg::POP_BACK:  popped = cell_q[back_pos[dwpi_pkg::IDX_W-1:0]];
			dwpi_pkg::POP_FRONT: popped = cell_q[0];
			default:             popped = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= dwpi_pkg::OUT_W'({cmd.size_after, cmd.status, popped});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/dwpi_checker.sv -----
`include "deque_with_positional_insert_assert.svh"

module dwpi_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [dwpi_pkg::OUT_W-1:0] m_tdata
);

	logic [dwpi_pkg::STATUS_W-1:0] status;
	logic [dwpi_pkg::CNT_W-1:0]    size_after;
	logic [dwpi_pkg::VALUE_W-1:0]  popped;
	logic                          stalled;
	logic                          full_rejected;
	logic                          empty_rejected;
	logic                          at_capacity;
	logic                          nothing_left;

	assign status     = m_tdata[dwpi_pkg::OUT_STAT_LSB +: dwpi_pkg::STATUS_W];
	assign size_after = m_tdata[dwpi_pkg::OUT_SIZE_LSB +: dwpi_pkg::CNT_W];
	assign popped     = m_tdata[dwpi_pkg::VALUE_W-1:0];

	// result word conditions
	assign stalled        = m_tvalid && !m_tready;
	assign full_rejected  = m_tvalid && (status == dwpi_pkg::ST_FULL);
	assign empty_rejected = m_tvalid && (status == dwpi_pkg::ST_EMPTY);
	assign at_capacity    = (size_after == dwpi_pkg::CNT_W'(dwpi_pkg::DEPTH));
	assign nothing_left   = (size_after == '0) && (popped == '0);

	// no result word while reset is held
	`DWPI_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !m_tvalid, "result valid during reset")

	// a stalled result word holds its contents
	`DWPI_ASSERT(a_result_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	// every accepted request word yields a result word next cycle
	`DWPI_ASSERT(a_result_follows, s_tvalid && s_tready |=> m_tvalid, "no result after request")

	// a full rejection reports the queue at capacity
	`DWPI_ASSERT(a_full_size, full_rejected |-> at_capacity, "full status with wrong size")

	// an empty rejection reports an empty queue and no popped word
	`DWPI_ASSERT(a_empty_size, empty_rejected |-> nothing_left, "empty status with data")

endmodule

bind deque_with_positional_insert dwpi_checker u_dwpi_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int N_RANDOM = 1880;
	localparam int LONG_HOLD = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS = 10;
	localparam int POS_MAX = (1 << dwpi_pkg::CNT_W) - 1;
	localparam logic [dwpi_pkg::ACTION_W-1:0] UNKNOWN_ACT_LO =
		dwpi_pkg::ACTION_W'(dwpi_pkg::ACT_INSERT + 1);
	localparam logic [dwpi_pkg::ACTION_W-1:0] UNKNOWN_ACT_HI =
		dwpi_pkg::ACTION_W'((1 << dwpi_pkg::ACTION_W) - 1);

	typedef struct {
		logic [dwpi_pkg::ACTION_W-1:0] action;
		dwpi_pkg::word_t               value;
		dwpi_pkg::count_t              position;
		logic                          wait_idle;
	} request_t;

	typedef struct {
		dwpi_pkg::word_t   popped;
		dwpi_pkg::status_t status;
		dwpi_pkg::count_t  size_after;
	} result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b1;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [dwpi_pkg::IN_W-1:0]     s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [dwpi_pkg::OUT_W-1:0]    m_tdata;

	// request words waiting to be offered, and results owed by the block
	request_t pending_requests[$];
	result_t  owed_results[$];
	// contents of the deque as the block should hold them, front at index 0
	dwpi_pkg::word_t deque_image[$];

	request_t in_flight;
	logic [dwpi_pkg::IN_W-1:0] req_word;
	int gen_fill = 0;
	int words_sent = 0;
	int words_checked = 0;
	int mismatches = 0;
	int send_gap = 0;
	int send_burst = 0;
	int recv_stall = 0;
	int recv_burst = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	result_t seen;
	result_t owed;

	deque_with_positional_insert uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one request to the deque image and return the result it should produce
	function automatic result_t apply_request(request_t req);
		result_t res;
		res.popped = '0;
		res.status = dwpi_pkg::ST_DONE;
		case (req.action)
			dwpi_pkg::ACT_PUSH_BACK, dwpi_pkg::ACT_PUSH_FRONT, dwpi_pkg::ACT_INSERT: begin
				if (deque_image.size() >= dwpi_pkg::DEPTH)
					res.status = dwpi_pkg::ST_FULL;
				else if (req.action == dwpi_pkg::ACT_PUSH_BACK)
					deque_image.push_back(req.value);
				else if (req.action == dwpi_pkg::ACT_PUSH_FRONT)
					deque_image.push_front(req.value);
				else if (req.position > deque_image.size())
					res.status = dwpi_pkg::ST_RANGE;
				else
					deque_image.insert(req.position, req.value);
			end
			dwpi_pkg::ACT_POP_BACK: begin
				if (deque_image.size() == 0)
					res.status = dwpi_pkg::ST_EMPTY;
				else
					res.popped = deque_image.pop_back();
			end
			dwpi_pkg::ACT_POP_FRONT: begin
				if (deque_image.size() == 0)
					res.status = dwpi_pkg::ST_EMPTY;
				else
					res.popped = deque_image.pop_front();
			end
			default: begin
			end
		endcase
		res.size_after = dwpi_pkg::count_t'(deque_image.size());
		return res;
	endfunction

	// idle length: mostly none or short, now and then long, sometimes a run with none
	function automatic int pick_gap(ref int burst_left);
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic queue_request(input logic [dwpi_pkg::ACTION_W-1:0] act,
		input dwpi_pkg::word_t val, input dwpi_pkg::count_t pos, input logic wait_idle);
		request_t req;
		req = '{act, val, pos, wait_idle};
		pending_requests.push_back(req);
		// rough fill level on the stimulus side, used to aim inserts and phases
		if ((act == dwpi_pkg::ACT_PUSH_BACK || act == dwpi_pkg::ACT_PUSH_FRONT ||
			(act == dwpi_pkg::ACT_INSERT && pos <= gen_fill)) && gen_fill < dwpi_pkg::DEPTH)
			gen_fill++;
		else if ((act == dwpi_pkg::ACT_POP_BACK || act == dwpi_pkg::ACT_POP_FRONT) &&
			gen_fill > 0)
			gen_fill--;
	endtask

	task automatic note_failure(input string what);
		if (mismatches < MAX_REPORTS)
			$display("%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				owed_results.push_back(apply_request(in_flight));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
					(!pending_requests[0].wait_idle || words_sent == words_checked)) begin
					in_flight = pending_requests.pop_front();
					req_word = '0;
					req_word[dwpi_pkg::ACTION_W-1:0] = in_flight.action;
					req_word[dwpi_pkg::IN_VAL_LSB +: dwpi_pkg::VALUE_W] = in_flight.value;
					req_word[dwpi_pkg::IN_POS_LSB +: dwpi_pkg::CNT_W] = in_flight.position;
					s_tdata <= req_word;
					s_tvalid <= 1'b1;
					send_gap = pick_gap(send_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.popped = m_tdata[dwpi_pkg::VALUE_W-1:0];
				seen.status = dwpi_pkg::status_t'(
					m_tdata[dwpi_pkg::OUT_STAT_LSB +: dwpi_pkg::STATUS_W]);
				seen.size_after = m_tdata[dwpi_pkg::OUT_SIZE_LSB +: dwpi_pkg::CNT_W];
				if (owed_results.size() == 0) begin
					note_failure($sformatf(
						"result word with no request pending: popped %0d status %0d size %0d",
						seen.popped, seen.status, seen.size_after));
				end else begin
					owed = owed_results.pop_front();
					if (seen.popped !== owed.popped || seen.status !== owed.status ||
						seen.size_after !== owed.size_after)
						note_failure($sformatf(
							{"word %0d: expected popped %0d status %0d size %0d, ",
							"got popped %0d status %0d size %0d"},
							words_checked, owed.popped, owed.status, owed.size_after,
							seen.popped, seen.status, seen.size_after));
				end
				words_checked <= words_checked + 1;
				recv_stall = pick_gap(recv_burst);
				// long hold-offs so the block backs up and stalls its input
				if (words_checked == 300 || words_checked == 1100)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL deque_with_positional_insert");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin
		int roll;
		int kind;
		int phase_left;
		logic [dwpi_pkg::ACTION_W-1:0] act;
		dwpi_pkg::word_t val;
		dwpi_pkg::count_t pos;

		// falling reset edge so the asynchronous reset takes effect
		arst_n <= 1'b0;

		// empty queue: pops, inserts past the end, unknown actions
		queue_request(dwpi_pkg::ACT_POP_BACK, $urandom,
			dwpi_pkg::count_t'($urandom_range(0, POS_MAX)), 1'b0);
		queue_request(dwpi_pkg::ACT_POP_FRONT, $urandom,
			dwpi_pkg::count_t'($urandom_range(0, POS_MAX)), 1'b0);
		queue_request(dwpi_pkg::ACT_INSERT, 32'sd5, 5'd1, 1'b0);
		queue_request(dwpi_pkg::ACT_INSERT, 32'sd6, dwpi_pkg::count_t'(POS_MAX), 1'b0);
		queue_request(UNKNOWN_ACT_LO, $urandom,
			dwpi_pkg::count_t'($urandom_range(0, POS_MAX)), 1'b0);
		queue_request(UNKNOWN_ACT_HI, $urandom,
			dwpi_pkg::count_t'($urandom_range(0, POS_MAX)), 1'b0);
		// value extremes, then pop the last word from each end
		queue_request(dwpi_pkg::ACT_PUSH_BACK, 32'sh7fffffff, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_PUSH_FRONT, 32'sh80000000, dwpi_pkg::count_t'(POS_MAX), 1'b0);
		queue_request(dwpi_pkg::ACT_POP_BACK, 32'sd0, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_POP_FRONT, 32'sd0, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_PUSH_BACK, -32'sd1, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_POP_BACK, 32'sd0, 5'd0, 1'b0);
		// inserts at the end and in the middle
		queue_request(dwpi_pkg::ACT_INSERT, 32'sd0, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_INSERT, 32'sh5a5a5a5a, 5'd1, 1'b0);
		queue_request(dwpi_pkg::ACT_INSERT, 32'sha5a5a5a5, 5'd1, 1'b0);
		queue_request(dwpi_pkg::ACT_INSERT, 32'sd7, 5'd4, 1'b0);
		queue_request(dwpi_pkg::ACTION_W'(UNKNOWN_ACT_LO + 1), 32'sd0, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_POP_FRONT, 32'sd0, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_POP_BACK, 32'sd0, 5'd0, 1'b0);
		queue_request(dwpi_pkg::ACT_POP_BACK, 32'sd0, 5'd0, 1'b0);

		// random part in phases that lean toward filling, draining or neither
		phase_left = 0;
		kind = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (phase_left == 0) begin
				kind = $urandom_range(0, 2);
				phase_left = $urandom_range(8, 40);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				act = dwpi_pkg::ACTION_W'($urandom_range(UNKNOWN_ACT_LO, UNKNOWN_ACT_HI));
			else if ((kind == 0 && roll < 75) || (kind == 1 && roll < 28) ||
				(kind == 2 && roll < 52))
				act = (roll % 3 == 0) ? dwpi_pkg::ACT_PUSH_BACK :
					(roll % 3 == 1) ? dwpi_pkg::ACT_PUSH_FRONT : dwpi_pkg::ACT_INSERT;
			else
				act = roll[0] ? dwpi_pkg::ACT_POP_BACK : dwpi_pkg::ACT_POP_FRONT;

			roll = $urandom_range(0, 99);
			if (roll < 3)
				val = 32'sh7fffffff;
			else if (roll < 6)
				val = 32'sh80000000;
			else if (roll < 8)
				val = '0;
			else if (roll < 10)
				val = -32'sd1;
			else
				val = $urandom;

			roll = $urandom_range(0, 99);
			if (act != dwpi_pkg::ACT_INSERT || roll < 10)
				pos = dwpi_pkg::count_t'($urandom_range(0, POS_MAX));
			else if (roll < 25)
				pos = dwpi_pkg::count_t'(gen_fill);
			else
				pos = dwpi_pkg::count_t'($urandom_range(0, gen_fill));

			queue_request(act, val, pos, (i % 500) == 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// check between edges so the driver and monitor have settled
		while (pending_requests.size() != 0 || s_tvalid || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && owed_results.size() == 0)
			$display("PASS deque_with_positional_insert");
		else
			$display("FAIL deque_with_positional_insert");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dwpi_pkg.sv
rtl/dwpi_cell.sv
rtl/dwpi_ctrl.sv
rtl/deque_with_positional_insert.sv
rtl/dwpi_checker.sv
sim/testbench.sv
